FILE: sv/mined_block_validator_macros.svh
// Assertion macros used by the validator checker.
`ifndef MINED_BLOCK_VALIDATOR_MACROS_SVH
`define MINED_BLOCK_VALIDATOR_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MBV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define MBV_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/mbv_pkg.sv
// Types, constants and the CRC function of the mined block validator.
`timescale 1ns / 1ps
`default_nettype none
package mbv_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned HeightW = 31;
  localparam int unsigned DiffW   = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [HashW-1:0]   GenesisHash = 32'hAAAA_AAAA;
  localparam logic [HashW-1:0]   CrcPoly     = 32'hEDB8_8320;
  localparam logic [HashW-1:0]   CrcInit     = 32'hFFFF_FFFF;
  localparam logic [HeightW-1:0] HeightMax   = {HeightW{1'b1}};
  localparam logic [HeightW-1:0] HeightReset = HeightW'(1);

  typedef enum logic [1:0] {
    StAccepted = 2'd0,
    StLowWork  = 2'd1,
    StMismatch = 2'd2,
    StBadLink  = 2'd3
  } mbv_status_e;

  // One word handed from the front to the back.
  typedef struct packed {
    mbv_status_e       pre_status;
    logic [HashW-1:0]  crc;
    logic [HashW-1:0]  link_hash;
    logic [HashW-1:0]  height;
  } mbv_entry_t;

  // Reflected CRC over one little-endian word: fold the word in, then 32 bit steps.
  function automatic logic [HashW-1:0] crc_word(input logic [HashW-1:0] crc,
                                                input logic [HashW-1:0] data);
    logic [HashW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < HashW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mbv_front.sv
// Front end: difficulty register, CRC-32 of the block and the stateless checks.
`timescale 1ns / 1ps
`default_nettype none
module mbv_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mbv_pkg::DiffW-1:0]        cfg_wdata_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_height_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_time_i,
  input  wire logic [mbv_pkg::HashW-1:0]        previous_hash_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_nonce_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] miner_id_i,
  input  wire logic [mbv_pkg::HashW-1:0]        claimed_hash_i,
  output mbv_pkg::mbv_entry_t                   entry_o
);

  logic [mbv_pkg::DiffW-1:0] difficulty_q;
  logic [mbv_pkg::HashW-1:0] crc;
  logic [mbv_pkg::HashW-1:0] top_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      difficulty_q <= '0;
    end else if (cfg_we_i) begin
      difficulty_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    crc = mbv_pkg::CrcInit;
    crc = mbv_pkg::crc_word(crc, block_height_i);
    crc = mbv_pkg::crc_word(crc, block_time_i);
    crc = mbv_pkg::crc_word(crc, previous_hash_i);
    crc = mbv_pkg::crc_word(crc, block_nonce_i);
    crc = mbv_pkg::crc_word(crc, miner_id_i);
    crc = crc ^ mbv_pkg::CrcInit;
  end

  // The top difficulty bits of the hash must all be zero.
  assign top_mask = ~({mbv_pkg::HashW{1'b1}} >> difficulty_q);

  always_comb begin
    entry_o.crc       = crc;
    entry_o.link_hash = previous_hash_i;
    entry_o.height    = block_height_i;
    if ((crc & top_mask) != '0) begin
      entry_o.pre_status = mbv_pkg::StLowWork;
    end else if (crc != claimed_hash_i) begin
      entry_o.pre_status = mbv_pkg::StMismatch;
    end else begin
      entry_o.pre_status = mbv_pkg::StAccepted;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mbv_fifo.sv
// Short queue of classified words between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module mbv_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  input  wire mbv_pkg::mbv_entry_t wr_entry_i,
  output logic               full_o,
  output logic               rd_valid_o,
  output mbv_pkg::mbv_entry_t rd_entry_o,
  input  wire logic          rd_ready_i
);

  localparam int unsigned PtrW = (mbv_pkg::QueueDepth > 1) ? $clog2(mbv_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(mbv_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(mbv_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(mbv_pkg::QueueDepth);

  mbv_pkg::mbv_entry_t entries_q [mbv_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = (cnt_q == FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = entries_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/mbv_back.sv
// Back end: chain head and height check, state update and the result register.
`timescale 1ns / 1ps
`default_nettype none
module mbv_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire mbv_pkg::mbv_entry_t        in_entry_i,
  output logic                            in_ready_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [1:0]                      status_o,
  output logic [mbv_pkg::HashW-1:0]       computed_hash_o,
  output logic [mbv_pkg::HeightW-1:0]     next_height_o
);

  logic [mbv_pkg::HashW-1:0]   head_q, head_d;
  logic [mbv_pkg::HeightW-1:0] exp_q, exp_d;
  logic                        out_valid_q;
  mbv_pkg::mbv_status_e        status_q, status_d;
  logic [mbv_pkg::HashW-1:0]   hash_q;
  logic [mbv_pkg::HeightW-1:0] height_q;
  logic                        take, link_ok;

  // Advance whenever the result register is free or being drained.
  assign take       = in_valid_i && (!out_valid_q || pop_i);
  assign in_ready_o = !out_valid_q || pop_i;

  // A negative height has its top bit set and never links.
  assign link_ok = (in_entry_i.link_hash == head_q)
                && !in_entry_i.height[mbv_pkg::HashW-1]
                && (in_entry_i.height[mbv_pkg::HeightW-1:0] == exp_q);

  always_comb begin
    head_d   = head_q;
    exp_d    = exp_q;
    status_d = in_entry_i.pre_status;
    if (in_entry_i.pre_status == mbv_pkg::StAccepted) begin
      if (link_ok) begin
        // Claimed hash equals the computed one here.
        head_d = in_entry_i.crc;
        exp_d  = (exp_q == mbv_pkg::HeightMax) ? exp_q : exp_q + mbv_pkg::HeightW'(1);
      end else begin
        status_d = mbv_pkg::StBadLink;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= mbv_pkg::GenesisHash;
      exp_q       <= mbv_pkg::HeightReset;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        head_q      <= head_d;
        exp_q       <= exp_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      hash_q   <= in_entry_i.crc;
      height_q <= exp_d;
    end
  end

  assign empty_o         = !out_valid_q;
  assign status_o        = status_q;
  assign computed_hash_o = hash_q;
  assign next_height_o   = height_q;

endmodule
`default_nettype wire

FILE: sv/mined_block_validator.sv
// Top level of the mined block validator: front, word queue and back.
// A pushed word enters the queue, then the result register once that register is free.
// Throughput: one block per cycle if pop keeps up; the CRC-32 is one XOR tree in the front.
// A stalled result backs words up into the two-entry queue; full rises once both hold words.
// Reset: chain head 0xAAAAAAAA, expected height 1, difficulty 0, queue and result empty.
`timescale 1ns / 1ps
`default_nettype none
module mined_block_validator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mbv_pkg::DiffW-1:0]        cfg_wdata_i,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_height_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_time_i,
  input  wire logic [mbv_pkg::HashW-1:0]        previous_hash_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] block_nonce_i,
  input  wire logic signed [mbv_pkg::HashW-1:0] miner_id_i,
  input  wire logic [mbv_pkg::HashW-1:0]        claimed_hash_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [1:0]                            status_o,
  output logic [mbv_pkg::HashW-1:0]             computed_hash_o,
  output logic [mbv_pkg::HeightW-1:0]           next_height_o
);

  mbv_pkg::mbv_entry_t front_entry, queue_entry;
  logic                queue_valid, back_ready;

  mbv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .block_height_i (block_height_i),
    .block_time_i   (block_time_i),
    .previous_hash_i(previous_hash_i),
    .block_nonce_i  (block_nonce_i),
    .miner_id_i     (miner_id_i),
    .claimed_hash_i (claimed_hash_i),
    .entry_o        (front_entry)
  );

  mbv_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push),
    .wr_entry_i(front_entry),
    .full_o    (full),
    .rd_valid_o(queue_valid),
    .rd_entry_o(queue_entry),
    .rd_ready_i(back_ready)
  );

  mbv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (queue_valid),
    .in_entry_i     (queue_entry),
    .in_ready_o     (back_ready),
    .empty_o        (empty),
    .pop_i          (pop),
    .status_o       (status_o),
    .computed_hash_o(computed_hash_o),
    .next_height_o  (next_height_o)
  );

endmodule
`default_nettype wire

FILE: sv/mbv_checker.sv
// Port-level checks of the mined block validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "mined_block_validator_macros.svh"
module mbv_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         full,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [1:0]                   status_o,
  input wire logic [mbv_pkg::HashW-1:0]    computed_hash_o,
  input wire logic [mbv_pkg::HeightW-1:0]  next_height_o
);

  // Hold the waiting result until it is taken.
  `MBV_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(status_o) && $stable(computed_hash_o) && $stable(next_height_o), "result changed while stalled")

  // The queue only fills up behind a stalled result.
  `MBV_ASSERT(a_full_needs_result, clk_i, rst_ni, !full || !empty, "full without a waiting result")

  // An all-zero hash meets every difficulty.
  `MBV_ASSERT(a_low_work_nonzero, clk_i, rst_ni, empty || (status_o != mbv_pkg::StLowWork) || (computed_hash_o != '0), "zero hash rejected for low work")

  // Expected height starts at one and saturates, so it is never zero.
  `MBV_ASSERT(a_height_nonzero, clk_i, rst_ni, empty || (next_height_o != '0), "next height is zero")

endmodule

bind mined_block_validator mbv_checker u_mbv_checker (.*);
`default_nettype wire
